>>> sv/ordered_list_insert_erase_top_macros.svh
// Assertion macros used by the list top module.
`ifndef ORDERED_LIST_INSERT_ERASE_TOP_MACROS_SVH
`define ORDERED_LIST_INSERT_ERASE_TOP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define OLIE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define OLIE_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

// A condition that must hold in the same cycle as a trigger.
`define OLIE_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

`endif

>>> sv/olie_pkg.sv
package olie_pkg;

    localparam int WORD_W = 32;
    localparam int POS_W = 5;
    localparam int CMD_W = 3;
    localparam int CNT_OUT_W = 5;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 104;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_ERASE  = 3'd2,
        CMD_READ   = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_ERASE  = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [WORD_W-1:0] value;
    } cell_ctl_t;

endpackage

>>> sv/olie_cell.sv
module olie_cell
    import olie_pkg::*;
#(
    parameter int IDX = 0,
    parameter int PW = 5
)
(
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic [PW-1:0]     pos,
    input  logic [WORD_W-1:0] left_data,
    input  logic [WORD_W-1:0] right_data,
    input  logic              rd_en,
    input  logic [PW-1:0]     rd_pos,
    input  logic [PW-1:0]     back_pos,
    output logic [WORD_W-1:0] data,
    output logic [WORD_W-1:0] rd_tap,
    output logic [WORD_W-1:0] back_tap
);

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.op)
            CELL_INSERT:
            begin
                if (MY_IDX > pos)
                begin
                    data_next = left_data;
                end
                else if (MY_IDX == pos)
                begin
                    data_next = ctl.value;
                end
            end
            CELL_ERASE:
            begin
                if (MY_IDX >= pos)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign rd_tap = (rd_en && (rd_pos == MY_IDX)) ? data_reg : '0;
    assign back_tap = (back_pos == MY_IDX) ? data_reg : '0;

endmodule

>>> sv/ordered_list_insert_erase_top.sv
// An accepted transaction goes to the pending stage, then its result is registered into the
// output stage once that stage can move. One transaction per cycle is taken while the output
// stage does not stall; insert and erase move every later entry one cell over on acceptance.
// Reset clears the entry count and the handshake state; entry words are not reset.
// The block accepts transactions in the first cycle after reset is released.
module ordered_list_insert_erase_top
    import olie_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: command (3), position (5), item_value (32).
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: read_word (32), front_word (32), back_word (32),
    // entry_count (5), status (2), one pad bit.
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    `include "ordered_list_insert_erase_top_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                pend_valid_reg;
    logic                pend_valid_next;
    status_t             pend_status_reg;
    logic                pend_rd_reg;
    logic [PW-1:0]       pend_pos_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;

    cmd_t                cmd;
    logic [PW-1:0]       pos_ext;
    logic [PW-1:0]       cnt_ext;
    logic [WORD_W-1:0]   value;
    logic                accept;
    logic                out_move;
    logic                full;
    status_t             status_a;
    logic                rd_a;
    cell_op_t            op_a;
    logic [PW-1:0]       op_pos;
    cell_ctl_t           ctl;

    logic [WORD_W-1:0]   cell_data [CAPACITY];
    logic [WORD_W-1:0]   rd_taps [CAPACITY];
    logic [WORD_W-1:0]   back_taps [CAPACITY];
    logic [WORD_W-1:0]   rd_word;
    logic [WORD_W-1:0]   back_word;
    logic [WORD_W-1:0]   front_word;
    logic [PW-1:0]       back_pos;

    assign cmd = cmd_t'(s_axis_tdata[CMD_W-1:0]);
    assign pos_ext = PW'(s_axis_tdata[CMD_W+POS_W-1:CMD_W]);
    assign value = s_axis_tdata[CMD_W+POS_W+WORD_W-1:CMD_W+POS_W];
    assign cnt_ext = PW'(count_reg);
    assign full = (count_reg == CW'(CAPACITY));

    assign out_move = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !pend_valid_reg || out_move;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        status_a = ST_OK;
        rd_a = 1'b0;
        op_a = CELL_HOLD;
        op_pos = pos_ext;
        count_next = count_reg;
        unique case (cmd)
            CMD_APPEND:
            begin
                if (full)
                begin
                    status_a = ST_FULL;
                end
                else
                begin
                    op_a = CELL_INSERT;
                    op_pos = cnt_ext;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_INSERT:
            begin
                if (full)
                begin
                    status_a = ST_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    status_a = ST_RANGE;
                end
                else
                begin
                    op_a = CELL_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_ERASE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_a = ST_RANGE;
                end
                else
                begin
                    op_a = CELL_ERASE;
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_READ:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_a = ST_RANGE;
                end
                else
                begin
                    rd_a = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status_a = ST_RANGE;
            end
        endcase
        if (!accept)
        begin
            op_a = CELL_HOLD;
            count_next = count_reg;
        end
    end

    assign ctl = '{op: op_a, value: value};

    // The result stage looks at the row after the update has landed.
    assign back_pos = cnt_ext - PW'(1);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_W-1:0] left_data;
        logic [WORD_W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = value;
        end
        else
        begin : g_mid_left
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_mid_right
            assign right_data = cell_data[i+1];
        end

        olie_cell #(
            .IDX (i),
            .PW  (PW)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .pos        (op_pos),
            .left_data  (left_data),
            .right_data (right_data),
            .rd_en      (pend_rd_reg),
            .rd_pos     (pend_pos_reg),
            .back_pos   (back_pos),
            .data       (cell_data[i]),
            .rd_tap     (rd_taps[i]),
            .back_tap   (back_taps[i])
        );
    end

    always_comb
    begin
        rd_word = '0;
        back_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_word = rd_word | rd_taps[i];
            back_word = back_word | back_taps[i];
        end
    end

    assign front_word = (count_reg != '0) ? cell_data[0] : '0;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (accept)
        begin
            pend_valid_next = 1'b1;
        end
        else if (out_move)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_move)
        begin
            out_valid_next = pend_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_rd_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                pend_rd_reg <= rd_a;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= status_a;
            pend_pos_reg <= pos_ext;
        end
        if (out_move && pend_valid_reg)
        begin
            out_data_reg <= {1'b0, pend_status_reg, cnt_ext[CNT_OUT_W-1:0],
                             back_word, front_word, rd_word};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    `OLIE_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(CAPACITY), "count above capacity")
    `OLIE_ASSERT_NEXT(a_clear_empties, accept && (cmd == CMD_CLEAR), count_reg == '0,
        "clear left entries")
    `OLIE_ASSERT_NEXT(a_pend_held, pend_valid_reg && !out_move, pend_valid_reg,
        "pending result dropped")
    `OLIE_ASSERT_SAME(a_empty_words,
        out_valid_reg && (out_data_reg[3*WORD_W+CNT_OUT_W-1:3*WORD_W] == '0),
        out_data_reg[3*WORD_W-1:WORD_W] == '0, "empty list shows words")

endmodule

>>> verif/tb_ordered_list_insert_erase_top.sv
`timescale 1ns / 100ps

module tb_ordered_list_insert_erase_top
    import olie_pkg::*;
();

    localparam int LIST_DEPTH = 16;
    localparam int POS_CODES = 1 << POS_W;
    localparam int CMD_CODES = 1 << CMD_W;

    typedef struct {
        logic [WORD_W-1:0]    read_word;
        logic [WORD_W-1:0]    front_word;
        logic [WORD_W-1:0]    back_word;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [1:0]           status;
    } list_result_t;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_SELDOM,
        READY_EVERY_THIRD
    } ready_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [WORD_W-1:0] list_words [LIST_DEPTH];
    int                list_count = 0;
    list_result_t      expected_results [$];

    int error_count = 0;
    int commands_sent = 0;
    int results_checked = 0;
    int times_full = 0;
    int times_emptied = 0;

    int burst_left = 0;
    bit gaps_on = 1'b1;
    int hold_off_request = 0;

    ready_mode_t ready_mode = READY_ALWAYS;
    int          mode_left = 0;
    int          hold_off_left = 0;
    int          third_phase = 0;

    ordered_list_insert_erase_top #(
        .CAPACITY(LIST_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic list_result_t predict_list_command(input logic [CMD_W-1:0] cmd,
                                                          input int pos,
                                                          input logic [WORD_W-1:0] value);
        list_result_t r;
        int           count_before;
        count_before = list_count;
        r.read_word = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_APPEND:
            begin
                if (list_count >= LIST_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    list_words[list_count] = value;
                    list_count++;
                end
            end
            CMD_INSERT:
            begin
                if (list_count >= LIST_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else if (pos > list_count)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    for (int i = list_count; i > pos; i--)
                    begin
                        list_words[i] = list_words[i-1];
                    end
                    list_words[pos] = value;
                    list_count++;
                end
            end
            CMD_ERASE:
            begin
                if (pos >= list_count)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    for (int i = pos; i + 1 < list_count; i++)
                    begin
                        list_words[i] = list_words[i+1];
                    end
                    list_count--;
                end
            end
            CMD_READ:
            begin
                if (pos >= list_count)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    r.read_word = list_words[pos];
                end
            end
            CMD_CLEAR:
            begin
                list_count = 0;
            end
            default:
            begin
                r.status = ST_RANGE;
            end
        endcase
        r.front_word = (list_count > 0) ? list_words[0] : '0;
        r.back_word = (list_count > 0) ? list_words[list_count-1] : '0;
        r.entry_count = CNT_OUT_W'(list_count);
        if (list_count == LIST_DEPTH && count_before != LIST_DEPTH)
        begin
            times_full++;
        end
        if (list_count == 0 && count_before != 0)
        begin
            times_emptied++;
        end
        return r;
    endfunction

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [WORD_W-1:0] value);
        if (burst_left == 0)
        begin
            repeat (gaps_on ? $urandom_range(1, 6) : 1) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {value, pos, cmd};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        expected_results.insert(expected_results.size(),
                                predict_list_command(cmd, int'(pos), value));
        commands_sent++;
        if (gaps_on)
        begin
            burst_left--;
            if (burst_left == 0)
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    endtask

    task automatic finish_sending();
        if (burst_left != 0)
        begin
            burst_left = 0;
            s_axis_tvalid <= 1'b0;
        end
    endtask

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'hffff_ffff;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position(input logic [CMD_W-1:0] cmd);
        if ($urandom_range(0, 15) == 0)
        begin
            return POS_W'($urandom_range(0, POS_CODES - 1));
        end
        if (cmd == CMD_INSERT)
        begin
            return POS_W'($urandom_range(0, list_count));
        end
        if (list_count == 0)
        begin
            return '0;
        end
        return POS_W'($urandom_range(0, list_count - 1));
    endfunction

    task automatic send_random_command(input bit growing);
        logic [CMD_W-1:0] cmd;
        int               roll;
        roll = $urandom_range(0, 99);
        if (growing)
        begin
            if (roll < 35) cmd = CMD_APPEND;
            else if (roll < 65) cmd = CMD_INSERT;
            else if (roll < 77) cmd = CMD_ERASE;
            else if (roll < 95) cmd = CMD_READ;
            else if (roll < 96) cmd = CMD_CLEAR;
            else cmd = CMD_W'($urandom_range(int'(CMD_CLEAR) + 1, CMD_CODES - 1));
        end
        else
        begin
            if (roll < 12) cmd = CMD_APPEND;
            else if (roll < 24) cmd = CMD_INSERT;
            else if (roll < 69) cmd = CMD_ERASE;
            else if (roll < 94) cmd = CMD_READ;
            else if (roll < 96) cmd = CMD_CLEAR;
            else cmd = CMD_W'($urandom_range(int'(CMD_CLEAR) + 1, CMD_CODES - 1));
        end
        send_command(cmd, pick_position(cmd), pick_value());
    endtask

    task automatic test_directed_cases();
        send_command(CMD_READ, '0, '0);
        send_command(CMD_ERASE, '0, '0);
        send_command(CMD_INSERT, 5'd1, 32'h1234_5678);
        send_command(CMD_INSERT, '0, 32'h0000_0001);
        send_command(CMD_APPEND, '0, 32'h7fff_ffff);
        send_command(CMD_APPEND, '1, 32'h8000_0000);
        send_command(CMD_INSERT, 5'd3, 32'hffff_ffff);
        send_command(CMD_INSERT, 5'd2, 32'hdead_beef);
        send_command(CMD_READ, '0, 32'hffff_ffff);
        send_command(CMD_READ, 5'd4, '0);
        send_command(CMD_READ, 5'd5, '0);
        send_command(CMD_READ, '1, '0);
        send_command(CMD_ERASE, 5'd2, '0);
        send_command(CMD_ERASE, 5'd3, '0);
        send_command(CMD_W'(int'(CMD_CLEAR) + 1), 5'd1, 32'h5555_5555);
        send_command(CMD_W'(CMD_CODES - 1), '1, 32'haaaa_aaaa);
        send_command(CMD_ERASE, '0, '0);
        send_command(CMD_CLEAR, '1, '1);
    endtask

    task automatic test_fill_to_capacity();
        send_command(CMD_CLEAR, '0, '0);
        while (list_count < LIST_DEPTH)
        begin
            send_command(CMD_APPEND, POS_W'($urandom), pick_value());
        end
        send_command(CMD_APPEND, '0, 32'h0bad_0bad);
        send_command(CMD_INSERT, 5'd3, 32'h0bad_0bad);
        send_command(CMD_INSERT, '1, 32'h0bad_0bad);
        send_command(CMD_READ, POS_W'(LIST_DEPTH - 1), '0);
        send_command(CMD_READ, POS_W'(LIST_DEPTH), '0);
        send_command(CMD_ERASE, POS_W'(LIST_DEPTH - 1), '0);
        send_command(CMD_INSERT, '0, pick_value());
        send_command(CMD_ERASE, '0, '0);
    endtask

    task automatic test_receiver_hold_off();
        gaps_on = 1'b0;
        hold_off_request = 300;
        repeat (40)
        begin
            send_random_command(1'b1);
        end
        gaps_on = 1'b1;
        burst_left = 1;
    endtask

    task automatic test_random_commands(input int total);
        bit growing;
        int phase_left;
        growing = 1'b1;
        phase_left = 0;
        repeat (total)
        begin
            if (phase_left == 0)
            begin
                growing = !growing;
                phase_left = $urandom_range(30, 80);
            end
            phase_left--;
            send_random_command(growing);
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_off_request != 0)
        begin
            hold_off_left = hold_off_request;
            hold_off_request = 0;
        end
        if (mode_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 200);
        end
        mode_left--;
        third_phase = (third_phase + 1) % 3;
        if (hold_off_left != 0)
        begin
            hold_off_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (ready_mode)
                READY_ALWAYS: m_axis_tready <= 1'b1;
                READY_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
                READY_SELDOM: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (third_phase == 0);
            endcase
        end
    end

    function automatic void check_field(input string field_name, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, actual %h", $time, field_name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        list_result_t want;
        list_result_t got;
        logic         pad_bit;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            {pad_bit, got.status, got.entry_count, got.back_word, got.front_word,
             got.read_word} = m_axis_tdata;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual %h",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("read_word", want.read_word, got.read_word);
                check_field("front_word", want.front_word, got.front_word);
                check_field("back_word", want.back_word, got.back_word);
                check_field("entry_count", WORD_W'(want.entry_count), WORD_W'(got.entry_count));
                check_field("status", WORD_W'(want.status), WORD_W'(got.status));
                results_checked++;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_fill_to_capacity();
        test_receiver_hold_off();
        test_random_commands(780);
        finish_sending();
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        $display("Sent %0d commands and checked %0d results.", commands_sent, results_checked);
        $display("The list filled up %0d times and emptied %0d times.", times_full,
                 times_emptied);
        if (error_count == 0)
        begin
            $display("ordered_list_insert_erase_top: match");
        end
        else
        begin
            $display("ordered_list_insert_erase_top: mismatch");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timed out with %0d results outstanding.", expected_results.size());
        $display("ordered_list_insert_erase_top: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/olie_pkg.sv
sv/olie_cell.sv
sv/ordered_list_insert_erase_top.sv
verif/tb_ordered_list_insert_erase_top.sv
